FILE: design/ptrt_pkg.sv
// ptrt_pkg: shared types and constants for the periodic task release timers
// no dependencies; used by ptrt_cell and periodic_task_release_timers
package ptrt_pkg;

    localparam int DEFAULT_SLOTS = 32;
    localparam int MAX_SLOTS     = 32;
    localparam int TIME_W        = 8;
    localparam int MASK_W        = 32;
    localparam int SLOT_W        = 5;

    // function codes of an input transfer
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    typedef logic [TIME_W-1:0] t_time;

    // command broadcast to every cell
    typedef struct packed {
        logic  tick;
        logic  add;
        t_time period;
        t_time first;
    } t_cell_cmd;

    // status returned by each cell
    typedef struct packed {
        logic active;
        logic released;
    } t_cell_stat;

endpackage

FILE: design/ptrt_cell.sv
// ptrt_cell: one release counter slot (period, countdown, occupied flag)
// depends on ptrt_pkg; chained by periodic_task_release_timers
module ptrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptrt_pkg::t_cell_cmd i_cmd,
    input  logic                i_prev_active,
    output ptrt_pkg::t_cell_stat o_stat
);
    import ptrt_pkg::*;

    logic  r_active;
    logic  n_active;
    t_time r_period;
    t_time n_period;
    t_time r_count;
    t_time n_count;
    logic  w_take;
    logic  w_release;

    // first free cell behind an occupied neighbour takes the add
    assign w_take    = i_cmd.add && i_prev_active && !r_active;
    assign w_release = i_cmd.tick && r_active && (r_count == t_time'(1));

    always_comb begin
        n_active = r_active;
        n_period = r_period;
        n_count  = r_count;
        if (w_take) begin
            n_active = 1'b1;
            n_period = i_cmd.period;
            n_count  = i_cmd.first;
        end else if (i_cmd.tick && r_active) begin
            if (w_release) begin
                n_count = r_period;
            end else begin
                n_count = r_count - t_time'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period <= n_period;
        r_count  <= n_count;
    end

    assign o_stat.active   = r_active;
    assign o_stat.released = w_release;

endmodule

FILE: design/periodic_task_release_timers.sv
// periodic_task_release_timers: top level, a chain of release counter cells
// depends on ptrt_pkg and ptrt_cell
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  command   | start / busy         | i_func, i_task_period, i_start_offset
//  result    | o_valid (strobe)     | o_due_mask, o_assigned_slot, o_add_accepted
//
// one transfer per cycle: every cell updates its own countdown in parallel,
// so a registered result appears in the cycle after the command transfer
// o_valid is high for exactly one cycle per result; the receiver cannot stall
// busy is never raised since the cell row can take a new command before the last result is out
// synchronous active-low reset empties every slot and clears the strobe
module periodic_task_release_timers #(
    parameter int TASK_SLOTS = ptrt_pkg::DEFAULT_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_func,
    input  logic [ptrt_pkg::TIME_W-1:0] i_task_period,
    input  logic [ptrt_pkg::TIME_W-1:0] i_start_offset,
    output logic                       o_valid,
    output logic [ptrt_pkg::MASK_W-1:0] o_due_mask,
    output logic [ptrt_pkg::SLOT_W-1:0] o_assigned_slot,
    output logic                       o_add_accepted
);
    import ptrt_pkg::*;

    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    logic                    w_go;
    logic                    w_full;
    t_cell_cmd               w_cmd;
    t_cell_stat              w_stat [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]   w_active;
    logic [TASK_SLOTS-1:0]   w_released;
    logic [TASK_SLOTS:0]     w_chain;

    // number of occupied slots; the next add lands at this index
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_valid;
    logic [MASK_W-1:0]       r_due;
    logic [MASK_W-1:0]       n_due;
    logic [SLOT_W-1:0]       r_slot;
    logic [SLOT_W-1:0]       n_slot;
    logic                    r_acc;
    logic                    n_acc;

    assign busy   = 1'b0;
    assign w_go   = start && !busy;
    assign w_full = w_active[TASK_SLOTS-1];

    // command broadcast along the row
    assign w_cmd.tick   = w_go && (i_func == FUNC_TICK);
    assign w_cmd.add    = w_go && (i_func == FUNC_ADD);
    assign w_cmd.period = i_task_period;
    assign w_cmd.first  = i_task_period + i_start_offset;

    // occupied flag passed from each cell to the next; slot 0 sees a filled
    // neighbour so it is the first to take an add
    assign w_chain[0] = 1'b1;

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        ptrt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev_active(w_chain[g]),
            .o_stat       (w_stat[g])
        );
        assign w_active[g]   = w_stat[g].active;
        assign w_released[g] = w_stat[g].released;
        assign w_chain[g+1]  = w_stat[g].active;
    end

    always_comb begin
        n_count = r_count;
        n_due   = '0;
        n_slot  = '0;
        n_acc   = 1'b0;
        if (w_cmd.tick) begin
            n_due = MASK_W'(w_released);
        end else if (w_cmd.add && !w_full) begin
            n_count = r_count + CNT_W'(1);
            n_slot  = SLOT_W'(r_count);
            n_acc   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_go;
        end
    end

    // result payload, only meaningful while the strobe is high
    always_ff @(posedge i_clk) begin
        r_due  <= n_due;
        r_slot <= n_slot;
        r_acc  <= n_acc;
    end

    assign o_valid         = r_valid;
    assign o_due_mask      = r_due;
    assign o_assigned_slot = r_slot;
    assign o_add_accepted  = r_acc;

`ifndef SYNTH
    // each command transfer yields exactly one result strobe
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_go) |-> o_valid)
        else $error("result strobe missing after command transfer");

    // occupied slots stay packed from slot 0 upwards
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_active >> 1) & ~w_active) == '0)
        else $error("occupied slots not contiguous");

    // slot counter matches the occupied flags in the row
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_active) == int'(r_count))
        else $error("slot count disagrees with cells");

    // an accepted add reports the slot that the counter pointed at
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_add_accepted) |-> (SLOT_W'($past(r_count)) == o_assigned_slot))
        else $error("assigned slot mismatch");

    // nothing is released without a tick
    a_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd.tick |-> (w_released == '0))
        else $error("release without tick");
`endif

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking testbench for periodic_task_release_timers
// depends on ptrt_pkg and the design; an in-bench release model predicts every result
module tb;
    import ptrt_pkg::*;

    localparam int SLOTS       = ptrt_pkg::DEFAULT_SLOTS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // one result transfer as the design presents it
    typedef struct {
        logic [MASK_W-1:0] due_mask;
        logic [SLOT_W-1:0] slot;
        logic              accepted;
    } t_release_result;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              busy;
    logic              i_func         = FUNC_TICK;
    t_time             i_task_period  = '0;
    t_time             i_start_offset = '0;
    logic              o_valid;
    logic [MASK_W-1:0] o_due_mask;
    logic [SLOT_W-1:0] o_assigned_slot;
    logic              o_add_accepted;

    // release model state: stores are only ever read below rel_active
    t_time             rel_period    [SLOTS];
    t_time             rel_countdown [SLOTS];
    logic [5:0]        rel_active = '0;

    t_release_result   pending_results[$];
    int                mismatches = 0;
    int                cycle_count = 0;
    int                sender_idle_pct = 0;

    periodic_task_release_timers #(
        .TASK_SLOTS (SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_task_period   (i_task_period),
        .i_start_offset  (i_start_offset),
        .o_valid         (o_valid),
        .o_due_mask      (o_due_mask),
        .o_assigned_slot (o_assigned_slot),
        .o_add_accepted  (o_add_accepted)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // runaway guard, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // advance the release model by one command and return what the design owes
    function automatic t_release_result predict_release(logic func, t_time period,
                                                        t_time offset);
        t_release_result r;
        t_time           next_cd;
        r.due_mask = '0;
        r.slot     = '0;
        r.accepted = 1'b0;
        if (func == FUNC_TICK) begin
            // only registered slots count down; a zero countdown wraps without release
            for (int s = 0; s < int'(rel_active); s++) begin
                next_cd = rel_countdown[s] - 8'd1;
                if (next_cd == '0) begin
                    next_cd       = rel_period[s];
                    r.due_mask[s] = 1'b1;
                end
                rel_countdown[s] = next_cd;
            end
        end else if (int'(rel_active) < SLOTS) begin
            rel_period[rel_active[SLOT_W-1:0]]    = period;
            rel_countdown[rel_active[SLOT_W-1:0]] = period + offset;
            r.slot                                = rel_active[SLOT_W-1:0];
            r.accepted                            = 1'b1;
            rel_active                            = rel_active + 6'd1;
        end
        // bank full: nothing changes and the result is all zero
        return r;
    endfunction

    // one command transfer: random sender gaps, junk payload while start is low
    task automatic send_command(logic func, t_time period, t_time offset);
        bit launched;
        launched = 1'b0;
        while (!launched) begin
            @(negedge i_clk);
            if ($urandom_range(99) < sender_idle_pct) begin
                start          <= 1'b0;
                i_func         <= 1'($urandom);
                i_task_period  <= 8'($urandom);
                i_start_offset <= 8'($urandom);
            end else begin
                start          <= 1'b1;
                i_func         <= func;
                i_task_period  <= period;
                i_start_offset <= offset;
                launched = 1'b1;
            end
        end
        // wait for the edge that takes the transfer
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        pending_results.push_back(predict_release(func, period, offset));
    endtask

    // result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_release_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: mask %h slot %0d accepted %b",
                             o_due_mask, o_assigned_slot, o_add_accepted);
            end else begin
                want = pending_results.pop_front();
                if (o_due_mask !== want.due_mask || o_assigned_slot !== want.slot ||
                    o_add_accepted !== want.accepted) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected mask %h slot %0d ",
                                  "accepted %b, got mask %h slot %0d accepted %b"},
                                 want.due_mask, want.slot, want.accepted,
                                 o_due_mask, o_assigned_slot, o_add_accepted);
                end
            end
        end
    end

    // extremes of every field, zero countdowns, zero period, early wraps
    task automatic test_directed_extremes();
        send_command(FUNC_TICK, 8'hFF, 8'hFF);  // tick on an empty bank
        send_command(FUNC_ADD,  8'h00, 8'h00);  // countdown starts at zero
        send_command(FUNC_ADD,  8'hFF, 8'hFF);  // sum wraps to 254
        send_command(FUNC_ADD,  8'h80, 8'h80);  // sum wraps to zero
        send_command(FUNC_ADD,  8'h01, 8'h00);  // released on every tick
        send_command(FUNC_ADD,  8'h00, 8'h01);  // period zero after first release
        send_command(FUNC_ADD,  8'h02, 8'hFF);  // offset wraps to one tick
        send_command(FUNC_ADD,  8'hAA, 8'h55);  // alternating bit patterns
        send_command(FUNC_ADD,  8'h55, 8'hAA);
        for (int n = 0; n < 6; n++)
            send_command(FUNC_TICK, 8'($urandom), 8'($urandom));
    endtask

    // fill the remaining slots among ticks, then knock on a full bank
    task automatic test_fill_bank();
        t_time period;
        t_time offset;
        while (int'(rel_active) < SLOTS) begin
            if ($urandom_range(99) < 30) begin
                // mostly short periods so releases are frequent
                case ($urandom_range(9))
                    0:       period = '0;
                    1, 2:    period = 8'($urandom);
                    default: period = 8'($urandom_range(12, 1));
                endcase
                offset = ($urandom_range(9) < 6) ? 8'($urandom_range(7)) : 8'($urandom);
                send_command(FUNC_ADD, period, offset);
            end else begin
                send_command(FUNC_TICK, 8'($urandom), 8'($urandom));
            end
        end
        send_command(FUNC_ADD, 8'hFF, 8'hFF);
        send_command(FUNC_ADD, 8'h00, 8'h00);
        send_command(FUNC_ADD, 8'($urandom), 8'($urandom));
    endtask

    // long run of ticks with the odd refused add mixed in
    task automatic test_release_traffic(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 8)
                send_command(FUNC_ADD, 8'($urandom), 8'($urandom));
            else
                send_command(FUNC_TICK, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 0;
        test_directed_extremes();
        sender_idle_pct = 27;
        test_fill_bank();
        test_release_traffic(500);
        sender_idle_pct = 79;
        test_release_traffic(500);
        sender_idle_pct = 0;
        test_release_traffic(600);

        @(negedge i_clk);
        start <= 1'b0;
        // drain, then keep watching for any stray strobe
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (pending_results.size() != 0)
            mismatches++;
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
